// File: rtl/core/dhtd_pkg.sv
// Shared types, codes and constants for the single-wire sensor edge decoder.
package dhtd_pkg;

  // Operation codes of an input item; code 3 is unused and ignored
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  // Configuration register indexes
  localparam logic REG_BIT_THRESHOLD = 1'b0;
  localparam logic REG_EDGE_TIMEOUT  = 1'b1;

  localparam int CFG_DATA_W  = 14;
  localparam int THRESH_W    = 8;
  localparam int TIMEOUT_W   = 14;
  localparam int EDGE_CNT_W  = 7;
  localparam int TIME_W      = 32;
  localparam int WORD_W      = 32;

  localparam logic [THRESH_W-1:0]   THRESH_RESET  = 8'd56;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET = 14'd7000;

  localparam logic [EDGE_CNT_W-1:0] REQUIRED_EDGES = 7'd66;
  localparam logic [EDGE_CNT_W-1:0] FIRST_BIT_EDGE = 7'd3;
  localparam logic [EDGE_CNT_W-1:0] LAST_BIT_EDGE  = 7'd65;

  localparam int MAX_CAPTURED_EDGES_DEFAULT = 82;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TIME_W-1:0] event_time_us;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] humidity_int;
    logic [7:0] humidity_frac;
    logic [7:0] temperature_int;
    logic [7:0] temperature_frac;
  } out_item_t;

endpackage

// File: rtl/core/dhtd_frame_core.sv
// Capture state, edge gap timing and bit assembly; one item per step.
module dhtd_frame_core #(
  parameter int MAX_CAPTURED_EDGES = dhtd_pkg::MAX_CAPTURED_EDGES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [dhtd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            step,
  input  dhtd_pkg::in_item_t              item,
  output logic                            has_result,
  output dhtd_pkg::out_item_t             result
);

  localparam logic [dhtd_pkg::EDGE_CNT_W-1:0] MaxEdges =
    dhtd_pkg::EDGE_CNT_W'(MAX_CAPTURED_EDGES);

  logic [dhtd_pkg::THRESH_W-1:0]   bit_threshold_us;
  logic [dhtd_pkg::TIMEOUT_W-1:0]  edge_timeout_us;
  logic                            capturing;
  logic [dhtd_pkg::EDGE_CNT_W-1:0] edge_count;
  logic [dhtd_pkg::TIME_W-1:0]     last_event_time;
  logic [dhtd_pkg::WORD_W-1:0]     bit_word;

  logic                            capturing_next;
  logic [dhtd_pkg::EDGE_CNT_W-1:0] edge_count_next;
  logic [dhtd_pkg::TIME_W-1:0]     last_event_time_next;
  logic [dhtd_pkg::WORD_W-1:0]     bit_word_next;

  logic [dhtd_pkg::TIME_W-1:0]     gap;
  logic                            timed_out;
  logic                            bit_edge;
  logic                            ok;

  assign gap       = item.event_time_us - last_event_time;
  assign timed_out = gap > {{(dhtd_pkg::TIME_W-dhtd_pkg::TIMEOUT_W){1'b0}}, edge_timeout_us};
  assign bit_edge  = edge_count[0] && (edge_count >= dhtd_pkg::FIRST_BIT_EDGE)
                     && (edge_count <= dhtd_pkg::LAST_BIT_EDGE);

  always_comb begin
    capturing_next       = capturing;
    edge_count_next      = edge_count;
    last_event_time_next = last_event_time;
    bit_word_next        = bit_word;
    has_result           = 1'b0;
    case (item.operation)
      dhtd_pkg::OP_BEGIN: begin
        capturing_next       = 1'b1;
        edge_count_next      = '0;
        bit_word_next        = '0;
        last_event_time_next = item.event_time_us;
      end
      dhtd_pkg::OP_EDGE, dhtd_pkg::OP_CHECK: begin
        if (capturing) begin
          if (timed_out) begin
            capturing_next = 1'b0;
            has_result     = 1'b1;
          end else if (item.operation == dhtd_pkg::OP_EDGE) begin
            if (bit_edge) begin
              bit_word_next = {bit_word[dhtd_pkg::WORD_W-2:0],
                               (gap > {{(dhtd_pkg::TIME_W-dhtd_pkg::THRESH_W){1'b0}},
                                       bit_threshold_us})};
            end
            edge_count_next      = edge_count + 1'b1;
            last_event_time_next = item.event_time_us;
            if (edge_count_next >= MaxEdges) begin
              capturing_next = 1'b0;
              has_result     = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result is formed from the post-update count and word
  assign ok = edge_count_next >= dhtd_pkg::REQUIRED_EDGES;
  always_comb begin
    result.status           = ~ok;
    result.humidity_int     = ok ? bit_word_next[31:24] : 8'd0;
    result.humidity_frac    = ok ? bit_word_next[23:16] : 8'd0;
    result.temperature_int  = ok ? bit_word_next[15:8]  : 8'd0;
    result.temperature_frac = ok ? bit_word_next[7:0]   : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_threshold_us <= dhtd_pkg::THRESH_RESET;
      edge_timeout_us  <= dhtd_pkg::TIMEOUT_RESET;
      capturing        <= 1'b0;
      edge_count       <= '0;
      last_event_time  <= '0;
      bit_word         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dhtd_pkg::REG_BIT_THRESHOLD: bit_threshold_us <= cfg_data[dhtd_pkg::THRESH_W-1:0];
          dhtd_pkg::REG_EDGE_TIMEOUT:  edge_timeout_us  <= cfg_data[dhtd_pkg::TIMEOUT_W-1:0];
          default: begin
          end
        endcase
      end
      if (step) begin
        capturing       <= capturing_next;
        edge_count      <= edge_count_next;
        last_event_time <= last_event_time_next;
        bit_word        <= bit_word_next;
      end
    end
  end

endmodule

// File: rtl/core/dhtd_out_reg.sv
// Result register holding one decoded frame until the consumer takes it.
module dhtd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  dhtd_pkg::out_item_t load_item,
  output logic                out_valid,
  input  logic                out_ready,
  output dhtd_pkg::out_item_t out_item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= load_item;
    end
  end

endmodule

// File: rtl/core/dht11_edge_timing_decoder.sv
// Top level of the single-wire humidity sensor edge timing decoder.
// Feed one item per line event: begin (opens a capture and starts the timeout
// window), edge (timestamp of a line transition) or check (timestamp only, to
// detect a timeout when no edge comes). Edges are numbered from zero after a
// begin; at odd edges 3..65 the gap to the previous edge is compared with
// bit_threshold_us and the bit shifts into a 32-bit word, MSB first. Capture
// closes when a gap exceeds edge_timeout_us (the edge that shows it is dropped)
// or when the count of transitions reaches MAX_CAPTURED_EDGES, and one result
// item is sent: the four word bytes with status 0, or status 1 and zero bytes
// if fewer than 66 transitions came. Throughput is one item per clock unless an
// item that closes a capture waits on an unread result. An accepted item is
// held in the input register and is then decoded into the result register,
// where its result shows on out_valid. An item that closes a capture waits in
// the input register while an earlier result is still unread, so in_ready
// follows out_ready combinationally in that case.
// Configuration writes are accepted at any time and take effect next cycle;
// write them only while no capture is in flight.
module dht11_edge_timing_decoder #(
  parameter int MAX_CAPTURED_EDGES = dhtd_pkg::MAX_CAPTURED_EDGES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [dhtd_pkg::CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dhtd_pkg::in_item_t              in_item,
  // result items
  output logic                            out_valid,
  input  logic                            out_ready,
  output dhtd_pkg::out_item_t             out_item
);

  // input register
  logic               q_valid;
  dhtd_pkg::in_item_t q_item;

  logic                has_result;
  dhtd_pkg::out_item_t result;
  logic                advance;

  // The held item retires when it makes no result or the result slot frees up
  assign advance  = q_valid && (!has_result || !out_valid || out_ready);
  assign in_ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_item <= in_item;
    end
  end

  dhtd_frame_core #(
    .MAX_CAPTURED_EDGES(MAX_CAPTURED_EDGES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .step       (advance),
    .item       (q_item),
    .has_result (has_result),
    .result     (result)
  );

  dhtd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_result),
    .load_item (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// File: rtl/core/dhtd_checker.sv
// Port-level checks for the edge timing decoder, bound to the top level.
module dhtd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input dhtd_pkg::out_item_t out_item
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // error frames carry zero bytes
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status |->
      out_item.humidity_int == 8'd0 && out_item.humidity_frac == 8'd0 &&
      out_item.temperature_int == 8'd0 && out_item.temperature_frac == 8'd0)
    else $error("error result with nonzero bytes");

  // reset empties the result slot
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // with the result slot empty nothing may block input
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result slot");

endmodule

bind dht11_edge_timing_decoder dhtd_checker u_dhtd_checker (.*);
